FILE: hw/rtl/spkf_pkg.sv
// ----------------------------------------------------------------------------
// spkf_pkg - static position fusion package
// Widths, reset constants, register indexes and word types shared by the
// position fusion block.
// ----------------------------------------------------------------------------
package spkf_pkg;

    localparam int POS_WIDTH     = 24;
    localparam int VAR_FRAC_BITS = 14;
    localparam int VAR_W         = 16;

    // magnitude of a position difference, product and divisor widths
    localparam int MAG_W  = POS_WIDTH + 1;
    localparam int PROD_W = MAG_W + VAR_W;
    localparam int SUM_W  = VAR_W + 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    localparam int VAR_ONE_I = (VAR_FRAC_BITS > 15) ? 65535 : (1 << VAR_FRAC_BITS);
    localparam logic [VAR_W-1:0] VAR_ONE      = VAR_W'(VAR_ONE_I);
    localparam logic [VAR_W-1:0] R_CAM_RESET  = VAR_W'((VAR_ONE_I + 5) / 10);
    localparam logic [VAR_W-1:0] R_RAD_RESET  = VAR_W'((2 * VAR_ONE_I + 5) / 10);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_R_CAMERA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R_RADAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_INITIAL = 2'd2;

    localparam logic SRC_CAMERA = 1'b0;
    localparam logic SRC_RADAR  = 1'b1;

    typedef struct packed {
        logic                        func;
        logic signed [POS_WIDTH-1:0] meas_x;
        logic signed [POS_WIDTH-1:0] meas_y;
    } in_word_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] fused_x;
        logic signed [POS_WIDTH-1:0] fused_y;
        logic        [VAR_W-1:0]     var_x_out;
        logic        [VAR_W-1:0]     var_y_out;
        logic                        first_fix;
    } out_word_t;

endpackage

FILE: hw/rtl/static_position_kalman_fusion_top.sv
// ----------------------------------------------------------------------------
// static_position_kalman_fusion_top - per-axis Kalman update of a static fix
// One shared multiplier and a one-bit-per-cycle restoring divider serve both
// axes and both divisions of the measurement update.
// ----------------------------------------------------------------------------
// Sequence: the first word after reset goes from idle straight to the output
// register; later words run, for each axis, setup and then multiply, divide
// and update for position and again for variance (an axis with zero sum skips
// its work). Input is taken only while the sequencer is idle, so a new word is
// not taken before the last one is through, and the sequencer waits while the
// output register stays full. The output register frees the sequencer while
// a result waits downstream.
// Reset (aresetn low, synchronous) clears the estimate, loads unit variance
// and the default noise registers, and empties the output register.
module static_position_kalman_fusion_top
    import spkf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAR_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [VAR_W-1:0] r_cam_reg, r_rad_reg, p_init_reg;

    logic signed [POS_WIDTH-1:0] est_x_reg, est_y_reg;
    logic        [VAR_W-1:0]     var_x_reg, var_y_reg;
    logic                        have_fix_reg;
    logic                        first_reg;

    logic signed [POS_WIDTH-1:0] z_x_reg, z_y_reg;
    logic        [VAR_W-1:0]     r_reg;
    logic                        axis_reg;   // 0 x, 1 y
    logic                        phase_reg;  // 0 position, 1 variance

    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [MAG_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic      m_valid_reg;
    out_word_t m_data_reg;

    // current axis operands
    logic signed [POS_WIDTH-1:0] pos_cur, z_cur;
    logic        [VAR_W-1:0]     var_cur;
    logic        [SUM_W-1:0]     sum_cur;
    logic signed [MAG_W-1:0]     diff_cur;
    logic        [MAG_W-1:0]     mul_a;
    logic        [PROD_W-1:0]    prod;
    logic        [SUM_W:0]       trial;
    logic                        ge;
    logic signed [MAG_W:0]       np_wide;
    logic signed [POS_WIDTH-1:0] np_sat;

    localparam logic signed [MAG_W:0] POS_MAX_W =
        (MAG_W+1)'({1'b0, {(POS_WIDTH-1){1'b1}}});
    localparam logic signed [MAG_W:0] POS_MIN_W =
        -(MAG_W+1)'({1'b1, {(POS_WIDTH-1){1'b0}}});

    assign pos_cur  = axis_reg ? est_y_reg : est_x_reg;
    assign z_cur    = axis_reg ? z_y_reg : z_x_reg;
    assign var_cur  = axis_reg ? var_y_reg : var_x_reg;
    assign sum_cur  = {1'b0, var_cur} + {1'b0, r_reg};
    assign diff_cur = {z_cur[POS_WIDTH-1], z_cur} - {pos_cur[POS_WIDTH-1], pos_cur};

    // shared multiplier: mag * var, then r * var
    assign mul_a = phase_reg ? {{(MAG_W-VAR_W){1'b0}}, r_reg} : mag_reg;
    assign prod  = mul_a * var_cur;

    // shared divider step
    assign trial = {rem_reg, div_reg[MAG_W-1]};
    assign ge    = trial >= {1'b0, sum_reg};

    always_comb begin
        if (neg_reg) begin
            np_wide = {pos_cur[POS_WIDTH-1], pos_cur[POS_WIDTH-1], pos_cur}
                      - $signed({1'b0, div_reg});
        end else begin
            np_wide = {pos_cur[POS_WIDTH-1], pos_cur[POS_WIDTH-1], pos_cur}
                      + $signed({1'b0, div_reg});
        end
        if (np_wide > POS_MAX_W) begin
            np_sat = {1'b0, {(POS_WIDTH-1){1'b1}}};
        end else if (np_wide < POS_MIN_W) begin
            np_sat = {1'b1, {(POS_WIDTH-1){1'b0}}};
        end else begin
            np_sat = np_wide[POS_WIDTH-1:0];
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = have_fix_reg ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP: begin
                if (sum_cur != '0) begin
                    state_next = ST_MUL;
                end else if (axis_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!phase_reg) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = axis_reg ? ST_DONE : ST_SETUP;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_cam_reg  <= R_CAM_RESET;
            r_rad_reg  <= R_RAD_RESET;
            p_init_reg <= VAR_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_R_CAMERA:  r_cam_reg  <= cfg_data;
                CFG_R_RADAR:   r_rad_reg  <= cfg_data;
                CFG_P_INITIAL: p_init_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            est_x_reg    <= '0;
            est_y_reg    <= '0;
            var_x_reg    <= VAR_ONE;
            var_y_reg    <= VAR_ONE;
            have_fix_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            axis_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            cnt_reg      <= '0;
            first_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        z_x_reg   <= s_data.meas_x;
                        z_y_reg   <= s_data.meas_y;
                        r_reg     <= (s_data.func == SRC_RADAR) ? r_rad_reg : r_cam_reg;
                        axis_reg  <= 1'b0;
                        phase_reg <= 1'b0;
                        first_reg <= !have_fix_reg;
                        if (!have_fix_reg) begin
                            // first fix: take the measurement as it stands
                            est_x_reg    <= s_data.meas_x;
                            est_y_reg    <= s_data.meas_y;
                            var_x_reg    <= p_init_reg;
                            var_y_reg    <= p_init_reg;
                            have_fix_reg <= 1'b1;
                        end
                    end
                end
                ST_SETUP: begin
                    sum_reg   <= sum_cur;
                    neg_reg   <= diff_cur[MAG_W-1];
                    mag_reg   <= diff_cur[MAG_W-1] ? MAG_W'(-diff_cur) : MAG_W'(diff_cur);
                    phase_reg <= 1'b0;
                    // zero sum: keep this axis and move on
                    if (sum_cur == '0) begin
                        axis_reg <= 1'b1;
                    end
                end
                ST_MUL: begin
                    // quotient fits the low bits, so preload the high part
                    if (!phase_reg) begin
                        rem_reg <= {1'b0, prod[PROD_W-1:MAG_W]};
                        div_reg <= prod[MAG_W-1:0];
                        cnt_reg <= CNT_W'(MAG_W);
                    end else begin
                        rem_reg <= {1'b0, prod[2*VAR_W-1:VAR_W]};
                        div_reg <= {prod[VAR_W-1:0], {(MAG_W-VAR_W){1'b0}}};
                        cnt_reg <= CNT_W'(VAR_W);
                    end
                end
                ST_DIV: begin
                    rem_reg <= ge ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
                    div_reg <= {div_reg[MAG_W-2:0], ge};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                ST_UPD: begin
                    if (!phase_reg) begin
                        if (axis_reg) begin
                            est_y_reg <= np_sat;
                        end else begin
                            est_x_reg <= np_sat;
                        end
                        phase_reg <= 1'b1;
                    end else begin
                        if (axis_reg) begin
                            var_y_reg <= div_reg[VAR_W-1:0];
                        end else begin
                            var_x_reg <= div_reg[VAR_W-1:0];
                        end
                        axis_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output word: load when the register is free
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.fused_x   <= est_x_reg;
            m_data_reg.fused_y   <= est_y_reg;
            m_data_reg.var_x_out <= var_x_reg;
            m_data_reg.var_y_out <= var_y_reg;
            m_data_reg.first_fix <= first_reg;
        end
    end

    a_div_rem_below_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < sum_reg))
        else $error("divider remainder not below divisor");

    a_div_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider running with zero count");

    a_first_fix_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !have_fix_reg) |=> (state_reg == ST_DONE && have_fix_reg))
        else $error("first fix did not go straight to output");

    a_fix_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        have_fix_reg |=> have_fix_reg)
        else $error("fix flag dropped without reset");

endmodule

FILE: test/tb_static_position_kalman_fusion_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_static_position_kalman_fusion_top - position fusion regression
// Drives camera and radar fixes into the fusion block under random flow
// control. A scoreboard carries its own copy of the per-axis estimate and
// noise registers and checks every fused word field by field, in order.
// ----------------------------------------------------------------------------
module tb_static_position_kalman_fusion_top;
    import spkf_pkg::*;

    localparam longint POS_MAX = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
    localparam longint POS_MIN = -(longint'(1) <<< (POS_WIDTH - 1));
    localparam logic signed [POS_WIDTH-1:0] POS_TOP    = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_BOTTOM = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic signed [POS_WIDTH-1:0] POS_ZERO   = '0;
    localparam logic signed [POS_WIDTH-1:0] POS_NEG1   = '1;
    localparam logic [VAR_W-1:0] VAR_TOP = '1;
    localparam logic [VAR_W-1:0] VAR_NIL = '0;
    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LONG_HOLD = 800;
    localparam int HOLD_AT   = 40;
    localparam int DRAIN     = 200;
    localparam int LIMIT_NS  = 3500000;

    class fusion_board;
        logic [VAR_W-1:0]            r_camera;
        logic [VAR_W-1:0]            r_radar;
        logic [VAR_W-1:0]            p_initial;
        logic signed [POS_WIDTH-1:0] est_x;
        logic signed [POS_WIDTH-1:0] est_y;
        logic [VAR_W-1:0]            var_x;
        logic [VAR_W-1:0]            var_y;
        logic                        have_fix;
        out_word_t                   expected_fixes[$];
        int                          errors;

        function new();
            r_camera  = R_CAM_RESET;
            r_radar   = R_RAD_RESET;
            p_initial = VAR_ONE;
            est_x     = '0;
            est_y     = '0;
            var_x     = VAR_ONE;
            var_y     = VAR_ONE;
            have_fix  = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAR_W-1:0] value);
            case (idx)
                CFG_R_CAMERA:  r_camera  = value;
                CFG_R_RADAR:   r_radar   = value;
                CFG_P_INITIAL: p_initial = value;
                default: ;
            endcase
        endfunction

        // one axis of the measurement update; a zero sum leaves the axis alone
        function void blend_axis(inout logic signed [POS_WIDTH-1:0] pos,
                                 inout logic [VAR_W-1:0] pvar,
                                 input logic signed [POS_WIDTH-1:0] z,
                                 input logic [VAR_W-1:0] r);
            longint sum;
            longint diff;
            longint mag;
            longint q;
            longint np;
            sum = longint'(pvar) + longint'(r);
            if (sum == 0) return;
            diff = longint'(z) - longint'(pos);
            mag  = (diff < 0) ? -diff : diff;
            q    = (mag * longint'(pvar)) / sum;
            np   = (diff < 0) ? longint'(pos) - q : longint'(pos) + q;
            if (np > POS_MAX) np = POS_MAX;
            if (np < POS_MIN) np = POS_MIN;
            pos  = np[POS_WIDTH-1:0];
            pvar = VAR_W'((longint'(pvar) * longint'(r)) / sum);
        endfunction

        function void take_measurement(in_word_t w);
            out_word_t        fix;
            logic [VAR_W-1:0] r;
            r = (w.func == SRC_RADAR) ? r_radar : r_camera;
            fix.first_fix = 1'b0;
            if (!have_fix) begin
                est_x    = w.meas_x;
                est_y    = w.meas_y;
                var_x    = p_initial;
                var_y    = p_initial;
                have_fix = 1'b1;
                fix.first_fix = 1'b1;
            end else begin
                blend_axis(est_x, var_x, w.meas_x, r);
                blend_axis(est_y, var_y, w.meas_y, r);
            end
            fix.fused_x   = est_x;
            fix.fused_y   = est_y;
            fix.var_x_out = var_x;
            fix.var_y_out = var_y;
            expected_fixes.push_back(fix);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_fix(out_word_t got);
            out_word_t want;
            if (expected_fixes.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_fixes.pop_front();
            check_field("fused_x", want.fused_x, got.fused_x);
            check_field("fused_y", want.fused_y, got.fused_y);
            check_field("var_x_out", want.var_x_out, got.var_x_out);
            check_field("var_y_out", want.var_y_out, got.var_y_out);
            check_field("first_fix", want.first_fix, got.first_fix);
        endfunction

        function int pending();
            return expected_fixes.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAR_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_word_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_word_t            m_data;

    fusion_board board = new();
    bit send_burst = 1'b0;
    bit rx_burst   = 1'b0;
    int fixes_seen = 0;
    int target_x   = 0;
    int target_y   = 0;

    static_position_kalman_fusion_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic in_word_t meas_word(logic func, logic signed [POS_WIDTH-1:0] x,
                                           logic signed [POS_WIDTH-1:0] y);
        in_word_t w;
        w.func   = func;
        w.meas_x = x;
        w.meas_y = y;
        return w;
    endfunction

    function automatic logic signed [POS_WIDTH-1:0] corner_pos();
        case ($urandom_range(0, 3))
            0:       return POS_TOP;
            1:       return POS_BOTTOM;
            2:       return POS_ZERO;
            default: return POS_NEG1;
        endcase
    endfunction

    // mostly scatter around the phase's target, some wild fixes and corners
    function automatic in_word_t random_meas();
        in_word_t w;
        int       pick;
        pick   = $urandom_range(0, 99);
        w.func = 1'($urandom_range(0, 1));
        if (pick < 70) begin
            w.meas_x = POS_WIDTH'(target_x + int'($urandom_range(0, 8191)) - 4096);
            w.meas_y = POS_WIDTH'(target_y + int'($urandom_range(0, 8191)) - 4096);
        end else if (pick < 90) begin
            w.meas_x = POS_WIDTH'($urandom);
            w.meas_y = POS_WIDTH'($urandom);
        end else begin
            w.meas_x = corner_pos();
            w.meas_y = corner_pos();
        end
        return w;
    endfunction

    task automatic send_meas(input in_word_t w);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.take_measurement(w);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        board.write_reg(idx, value);
    endtask

    task automatic program_regs(input logic [VAR_W-1:0] cam, input logic [VAR_W-1:0] rad,
                                input logic [VAR_W-1:0] pinit);
        cfg_write(CFG_R_CAMERA, cam);
        cfg_write(CFG_R_RADAR, rad);
        cfg_write(CFG_P_INITIAL, pinit);
        cfg_write(CFG_UNUSED, VAR_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid and hold until every fused word of the phase is back
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int count);
        int i;
        target_x = int'($urandom_range(0, 8388608)) - 4194304;
        target_y = int'($urandom_range(0, 8388608)) - 4194304;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
            send_meas(random_meas());
        end
        settle();
    endtask

    initial begin
        int ph;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: first fix loads unit variance, then default noise
        send_meas(meas_word(SRC_RADAR, POS_TOP, POS_BOTTOM));
        send_meas(meas_word(SRC_CAMERA, POS_BOTTOM, POS_TOP));
        send_meas(meas_word(SRC_RADAR, POS_ZERO, POS_ZERO));
        settle();

        program_regs(VAR_TOP, VAR_TOP, VAR_NIL);
        send_meas(meas_word(SRC_CAMERA, POS_TOP, POS_TOP));
        send_meas(meas_word(SRC_RADAR, POS_BOTTOM, POS_BOTTOM));
        send_meas(meas_word(SRC_CAMERA, POS_TOP, POS_BOTTOM));
        send_meas(meas_word(SRC_RADAR, POS_BOTTOM, POS_TOP));
        send_meas(meas_word(SRC_CAMERA, POS_ZERO, POS_ZERO));
        send_meas(meas_word(SRC_RADAR, POS_NEG1, 24'sd1));
        send_meas(meas_word(SRC_CAMERA, 24'sd1, POS_NEG1));
        send_meas(meas_word(SRC_RADAR, 24'sh400000, 24'shC00000));
        send_meas(meas_word(SRC_CAMERA, 24'shC00000, 24'sh400000));
        send_meas(meas_word(SRC_RADAR, POS_TOP, POS_TOP));
        send_meas(meas_word(SRC_RADAR, POS_TOP, POS_TOP));
        send_meas(meas_word(SRC_CAMERA, POS_BOTTOM, POS_BOTTOM));
        send_meas(meas_word(SRC_CAMERA, 24'sh555555, 24'shAAAAAA));
        send_meas(meas_word(SRC_RADAR, 24'shAAAAAA, 24'sh555555));
        settle();

        for (ph = 0; ph < 5; ph++) begin
            if (ph == 0)
                program_regs(VAR_TOP, VAR_TOP, VAR_TOP);
            else
                program_regs(VAR_W'($urandom_range(16384, 65535)),
                             VAR_W'($urandom_range(16384, 65535)), VAR_W'($urandom));
            run_random_phase(300);
        end

        // camera noise of zero collapses the variance, after which camera
        // fixes meet a zero sum and must leave the estimate untouched
        program_regs(VAR_NIL, VAR_W'($urandom_range(1, 65535)), VAR_W'($urandom));
        run_random_phase(150);
        program_regs(VAR_NIL, VAR_NIL, VAR_TOP);
        run_random_phase(50);

        repeat (DRAIN) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: random back-pressure, one long hold-off to fill the block
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (fixes_seen % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (fixes_seen == HOLD_AT) stall = LONG_HOLD;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            board.check_fix(m_data);
            fixes_seen++;
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/spkf_pkg.sv
hw/rtl/static_position_kalman_fusion_top.sv
test/tb_static_position_kalman_fusion_top.sv
